// ----- design/assert_macros.svh -----
// Assertion helper macros for the UART receive frame assembler.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("%m: assertion failed");

// Antecedent at one edge implies consequent at the next edge.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: assertion failed");

`endif

// ----- design/urfa_pkg.sv -----
// Shared types and constants for the UART receive frame assembler.
// No dependencies.
package urfa_pkg;

   localparam int BUF_DEPTH_DEFAULT = 64;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   // item kinds
   localparam logic [1:0] KIND_BYTE    = 2'd0;
   localparam logic [1:0] KIND_TICK    = 2'd1;
   localparam logic [1:0] KIND_READ    = 2'd2;
   localparam logic [1:0] KIND_RELEASE = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_IDLE_TIMEOUT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_FIRST    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_END_SECOND   = 2'd2;

   localparam logic [6:0] IDLE_TIMEOUT_RESET = 7'd10;
   localparam logic [7:0] END_FIRST_RESET    = 8'h0D;
   localparam logic [7:0] END_SECOND_RESET   = 8'h09;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data_byte;
      logic [5:0] read_index;
   } req_type;

   typedef struct packed {
      logic       frame_ready;
      logic [6:0] frame_length;
      logic [7:0] read_byte;
      logic       receiving;
      logic       byte_taken;
   } rsp_type;

   typedef struct packed {
      logic [6:0] idle_timeout;
      logic [7:0] end_first;
      logic [7:0] end_second;
   } cfg_type;

endpackage

// ----- design/urfa_store.sv -----
// Frame byte store: one write port, one registered read port.
// Depends on nothing but its parameter.
module urfa_store #(
   parameter int BUF_DEPTH = 64
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(BUF_DEPTH)-1:0] wr_addr,
   input  logic [7:0]                   wr_data,
   input  logic                         rd_en,
   input  logic [$clog2(BUF_DEPTH)-1:0] rd_addr,
   output logic [7:0]                   rd_data
);

   logic [7:0] store_ff [BUF_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/urfa_framer.sv -----
// Framing state: write position, timer, terminator match, pending frame.
// Depends on urfa_pkg; drives the write and read ports of urfa_store.
module urfa_framer #(
   parameter int BUF_DEPTH = urfa_pkg::BUF_DEPTH_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         item_en,
   input  urfa_pkg::req_type            item,
   input  urfa_pkg::cfg_type            cfg,
   output logic                         wr_en,
   output logic [$clog2(BUF_DEPTH)-1:0] wr_addr,
   output logic [7:0]                   wr_data,
   output logic                         rd_en,
   output logic [$clog2(BUF_DEPTH)-1:0] rd_addr,
   output urfa_pkg::rsp_type            status
);
   import urfa_pkg::*;

   localparam int ADDR_W = $clog2(BUF_DEPTH);
   localparam logic [ADDR_W:0]   DEPTH_LEN = (ADDR_W+1)'(BUF_DEPTH);
   localparam logic [ADDR_W+6:0] DEPTH_CMP = (ADDR_W+7)'(BUF_DEPTH);

   logic [ADDR_W-1:0] wpos_ff, wpos_in;
   logic [6:0]        clen_ff, clen_in;
   logic              pending_ff, pending_in;
   logic              gathering_ff, gathering_in;
   logic [6:0]        timer_ff, timer_in;
   logic [7:0]        prev_ff, prev_in;

   logic [ADDR_W:0]   npos;
   logic [ADDR_W:0]   close_len;
   logic [ADDR_W+7:0] len_wide;
   logic [ADDR_W+5:0] idx_wide;
   logic              do_close;
   logic              store_byte;

   assign npos     = {1'b0, wpos_ff} + (ADDR_W+1)'(1);
   assign idx_wide = {{ADDR_W{1'b0}}, item.read_index};
   assign len_wide = {7'd0, close_len};

   always_comb begin
      wpos_in      = wpos_ff;
      clen_in      = clen_ff;
      pending_in   = pending_ff;
      gathering_in = gathering_ff;
      timer_in     = timer_ff;
      prev_in      = prev_ff;
      do_close     = 1'b0;
      close_len    = npos;
      store_byte   = 1'b0;
      rd_en        = 1'b0;

      unique case (item.kind)
         KIND_BYTE: begin
            if (pending_ff) begin
               gathering_in = 1'b0;
               timer_in     = cfg.idle_timeout;
            end else if (wpos_ff != '0 && timer_ff == '0) begin
               // idle gap expired: close on what is held, drop this byte
               do_close  = 1'b1;
               close_len = {1'b0, wpos_ff};
            end else begin
               store_byte = 1'b1;
               if (wpos_ff == '0) begin
                  gathering_in = 1'b1;
               end
               timer_in = cfg.idle_timeout;
               prev_in  = item.data_byte;
               if ((wpos_ff != '0 && prev_ff == cfg.end_first &&
                    item.data_byte == cfg.end_second) || npos == DEPTH_LEN) begin
                  do_close = 1'b1;
               end else begin
                  wpos_in = npos[ADDR_W-1:0];
               end
            end
         end
         KIND_TICK: begin
            if (timer_ff != '0) begin
               timer_in = timer_ff - 7'd1;
            end
         end
         KIND_READ: begin
            rd_en = ({1'b0, idx_wide} < DEPTH_CMP);
         end
         KIND_RELEASE: begin
            pending_in = 1'b0;
         end
      endcase

      if (do_close) begin
         pending_in   = 1'b1;
         gathering_in = 1'b0;
         clen_in      = len_wide[6:0];
         wpos_in      = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wpos_ff      <= '0;
         clen_ff      <= '0;
         pending_ff   <= 1'b0;
         gathering_ff <= 1'b0;
         timer_ff     <= '0;
         prev_ff      <= '0;
      end else if (item_en) begin
         wpos_ff      <= wpos_in;
         clen_ff      <= clen_in;
         pending_ff   <= pending_in;
         gathering_ff <= gathering_in;
         timer_ff     <= timer_in;
         prev_ff      <= prev_in;
      end
   end

   assign wr_en   = item_en & store_byte;
   assign wr_addr = wpos_ff;
   assign wr_data = item.data_byte;
   assign rd_addr = idx_wide[ADDR_W-1:0];

   always_comb begin
      status              = '0;
      status.frame_ready  = pending_in;
      status.frame_length = clen_in;
      status.receiving    = gathering_in;
      status.byte_taken   = store_byte;
   end

endmodule

// ----- design/uart_rx_frame_assembler.sv -----
// UART receive frame assembler: turns received bytes into framed buffers.
// An accepted transaction's result is registered and shows on rsp_* in the following cycle.
// Throughput: one transaction per cycle while results are taken, set by the single output register.
// Reset (synchronous): framing state cleared, registers to defaults (10, 0x0D, 0x09).
// The frame store keeps no reset; entries hold data only once written.
// Depends on urfa_pkg, urfa_framer, urfa_store and assert_macros.svh.
`include "assert_macros.svh"

module uart_rx_frame_assembler #(
   parameter int BUF_DEPTH = urfa_pkg::BUF_DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request transactions
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  urfa_pkg::req_type                    req_data,
   // result transactions
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output urfa_pkg::rsp_type                    rsp_data,
   // register writes
   input  logic                                 csr_we,
   input  logic [urfa_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [urfa_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import urfa_pkg::*;

   localparam int ADDR_W = $clog2(BUF_DEPTH);

   cfg_type           cfg_ff;
   logic              req_fire;
   logic              out_valid_ff;
   rsp_type           rsp_ff;
   logic              rd_sel_ff;
   rsp_type           status;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [7:0]        rd_data;

   // The output register frees up whenever its result leaves in the same cycle,
   // so a stream of transactions moves at one per clock while results are taken.
   assign req_ready = !out_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   // Register file: the user must write it only while the block is quiet; the block does not enforce this.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.idle_timeout <= IDLE_TIMEOUT_RESET;
         cfg_ff.end_first    <= END_FIRST_RESET;
         cfg_ff.end_second   <= END_SECOND_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_IDLE_TIMEOUT: cfg_ff.idle_timeout <= csr_wdata[6:0];
            CSR_END_FIRST:    cfg_ff.end_first    <= csr_wdata;
            CSR_END_SECOND:   cfg_ff.end_second   <= csr_wdata;
            default: ;
         endcase
      end
   end

   urfa_framer #(
      .BUF_DEPTH (BUF_DEPTH)
   ) u_framer (
      .clock   (clock),
      .reset   (reset),
      .item_en (req_fire),
      .item    (req_data),
      .cfg     (cfg_ff),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .status  (status)
   );

   // Read data lands in the store's own output register on the same edge
   // that loads the result register, so both line up.
   urfa_store #(
      .BUF_DEPTH (BUF_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (req_fire & rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         rd_sel_ff    <= 1'b0;
      end else if (req_fire) begin
         out_valid_ff <= 1'b1;
         rd_sel_ff    <= rd_en;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= status;
      end
   end

   // Reads outside the buffer, and all non-read transactions, return zero.
   always_comb begin
      rsp_data           = rsp_ff;
      rsp_data.read_byte = rd_sel_ff ? rd_data : 8'd0;
   end

   assign rsp_valid = out_valid_ff;

   // A frame is never pending and being gathered at the same time.
   `ASSERT_ALWAYS(a_pending_excl, clock, reset, !(rsp_valid && rsp_data.frame_ready && rsp_data.receiving))
   // Every accepted transaction produces a result on the next cycle.
   `ASSERT_NEXT(a_result_follows, clock, reset, req_fire, rsp_valid)
   // Only received-byte transactions can report a stored byte.
   `ASSERT_NEXT(a_taken_only_byte, clock, reset, req_fire && req_data.kind != KIND_BYTE, !rsp_data.byte_taken)

endmodule

// ----- sim/tb_uart_rx_frame_assembler.sv -----
// Self-checking testbench for uart_rx_frame_assembler: byte, tick, read and release traffic
// is checked against a built-in frame predictor across several register settings.
// Depends on urfa_pkg and the assembler RTL.
module tb_uart_rx_frame_assembler;
   timeunit 1ns;
   timeprecision 1ps;

   import urfa_pkg::*;

   localparam int DEPTH = BUF_DEPTH_DEFAULT;
   // index with no register behind it; a write there must change nothing
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   logic clock;
   logic reset = 1'b1;

   logic     req_valid = 1'b0;
   logic     req_ready;
   req_type  req_data  = '0;
   logic     rsp_valid;
   logic     rsp_ready = 1'b0;
   rsp_type  rsp_data;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   uart_rx_frame_assembler #(.BUF_DEPTH(DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------------
   // Frame predictor state: shadow registers plus the framing state of the block
   // ---------------------------------------------------------------------------------------
   logic [6:0] cfg_timeout   = IDLE_TIMEOUT_RESET;
   logic [7:0] cfg_end_first = END_FIRST_RESET;
   logic [7:0] cfg_end_second = END_SECOND_RESET;

   logic [7:0] frame_mem [DEPTH];
   int         fill_count = 0;     // next write slot of the frame being gathered
   logic [6:0] done_len   = '0;    // length of the last closed frame
   logic       pending    = 1'b0;  // closed frame not yet released
   logic       gathering  = 1'b0;
   logic [6:0] idle_timer = '0;
   logic [7:0] last_byte  = '0;

   req_type    rx_items[$];        // transactions waiting for the driver
   rsp_type    expected_status[$]; // predicted results, oldest first
   int         queued_count = 0;
   int         mismatches   = 0;

   function automatic void close_frame(input int len);
      pending   = 1'b1;
      gathering = 1'b0;
      done_len  = len[6:0];
      fill_count = 0;
   endfunction

   // Advance the predicted framing state by one transaction and return its result.
   function automatic rsp_type assemble_step(input req_type item);
      rsp_type r;
      logic    taken;
      r = '0;
      taken = 1'b0;
      case (item.kind)
         KIND_BYTE: begin
            if (pending) begin
               // dropped, but it still kills gathering and reloads the timer
               gathering  = 1'b0;
               idle_timer = cfg_timeout;
            end else if (fill_count != 0 && idle_timer == 0) begin
               // idle timeout: close what we have, the late byte is lost, no reload
               close_frame(fill_count);
            end else begin
               if (fill_count == 0)
                  gathering = 1'b1;
               idle_timer = cfg_timeout;
               frame_mem[fill_count] = item.data_byte;
               fill_count++;
               taken = 1'b1;
               if (fill_count >= 2 && last_byte == cfg_end_first
                   && item.data_byte == cfg_end_second)
                  close_frame(fill_count);
               else if (fill_count >= DEPTH)
                  close_frame(DEPTH);
               last_byte = item.data_byte;
            end
         end
         KIND_TICK: begin
            if (idle_timer != 0)
               idle_timer--;
         end
         KIND_READ: begin
            r.read_byte = frame_mem[item.read_index];
         end
         default: begin
            pending = 1'b0;
         end
      endcase
      r.frame_ready  = pending;
      r.frame_length = done_len;
      r.receiving    = gathering;
      r.byte_taken   = taken;
      return r;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Driver: bursts of transactions separated by random gaps
   // ---------------------------------------------------------------------------------------
   int gap_left   = 0;
   int burst_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // predict at the edge where the transaction is accepted
         if (req_valid && req_ready)
            expected_status.push_back(assemble_step(req_data));
         // valid may only change once the held transaction has gone
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (rx_items.size() > 0) begin
               req_data  <= rx_items.pop_front();
               req_valid <= 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  // a third of the bursts run back to back with no gap at all
                  burst_left = $urandom_range(0, 30);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Receiver: stall pattern picked anew when rx_cycle[5:0] is zero; one long hold-off fills the block
   // ---------------------------------------------------------------------------------------
   logic [31:0] rx_cycle   = '0;
   int          stall_mode = 0;
   int          hold_left  = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rx_cycle <= rx_cycle + 32'd1;
         if (rx_cycle == 32'd600)
            hold_left = 300;   // sender keeps offering, so req_ready must drop
         if (rx_cycle[5:0] == 6'd0)
            stall_mode = $urandom_range(0, 3);
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            case (stall_mode)
               0:       rsp_ready <= 1'b1;
               1:       rsp_ready <= 1'($urandom_range(0, 1));
               2:       rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= rx_cycle[2];
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Monitor: every accepted result against the oldest prediction, field by field
   // ---------------------------------------------------------------------------------------
   rsp_type want;

   task automatic report_mismatch(input string what, input int got, input int exp_val);
      $display("mismatch %s: got 0x%0h expected 0x%0h at %0t", what, got, exp_val, $realtime);
      mismatches++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_status.size() == 0) begin
            report_mismatch("result with nothing outstanding", rsp_data, 0);
         end else begin
            want = expected_status.pop_front();
            if (rsp_data.frame_ready !== want.frame_ready)
               report_mismatch("frame_ready", rsp_data.frame_ready, want.frame_ready);
            if (rsp_data.frame_length !== want.frame_length)
               report_mismatch("frame_length", rsp_data.frame_length, want.frame_length);
            if (rsp_data.read_byte !== want.read_byte)
               report_mismatch("read_byte", rsp_data.read_byte, want.read_byte);
            if (rsp_data.receiving !== want.receiving)
               report_mismatch("receiving", rsp_data.receiving, want.receiving);
            if (rsp_data.byte_taken !== want.byte_taken)
               report_mismatch("byte_taken", rsp_data.byte_taken, want.byte_taken);
         end
      end
   end

   // ---------------------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------------------
   // Fields the kind does not use carry random noise.
   task automatic queue_item(input logic [1:0] k, input int arg);
      req_type item;
      item.kind       = k;
      item.data_byte  = 8'($urandom_range(0, 255));
      item.read_index = 6'($urandom_range(0, 63));
      if (k == KIND_BYTE)
         item.data_byte = arg[7:0];
      else if (k == KIND_READ)
         item.read_index = arg[5:0];
      rx_items.push_back(item);
      queued_count++;
   endtask

   // Nothing queued, nothing held, nothing outstanding, then idle margin for the registered output stage.
   task automatic wait_idle();
      while (rx_items.size() != 0 || req_valid || expected_status.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [7:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_IDLE_TIMEOUT: cfg_timeout    = val[6:0];
         CSR_END_FIRST:    cfg_end_first  = val;
         CSR_END_SECOND:   cfg_end_second = val;
         default: ;
      endcase
   endtask

   task automatic set_framing(input logic [7:0] tmo, input logic [7:0] first,
                              input logic [7:0] second);
      wait_idle();
      write_reg(CSR_IDLE_TIMEOUT, tmo);
      write_reg(CSR_END_FIRST, first);
      write_reg(CSR_END_SECOND, second);
      write_reg(CSR_SPARE, 8'($urandom_range(0, 255)));
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Mostly whole frames with random content: release, bytes with ticks between them,
   // optional terminator pair or forced idle timeout, then reads and an optional late byte.
   // The rest is unstructured noise.
   task automatic random_traffic(input int budget);
      int   start;
      int   n;
      bit   term;
      start = queued_count;
      while (queued_count - start < budget) begin
         if ($urandom_range(0, 9) < 7) begin
            queue_item(KIND_RELEASE, 0);
            n    = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 70) : $urandom_range(1, 8);
            term = ($urandom_range(0, 2) == 0) && n >= 2;
            for (int k = 0; k < n; k++) begin
               if (cfg_timeout <= 12 && $urandom_range(0, 5) == 0)
                  repeat (cfg_timeout) queue_item(KIND_TICK, 0);
               else
                  repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0)
                     queue_item(KIND_TICK, 0);
               if (term && k == n - 2)
                  queue_item(KIND_BYTE, cfg_end_first);
               else if (term && k == n - 1)
                  queue_item(KIND_BYTE, cfg_end_second);
               else
                  queue_item(KIND_BYTE, $urandom_range(0, 255));
            end
            repeat ($urandom_range(0, 3)) queue_item(KIND_READ, $urandom_range(0, 63));
            if ($urandom_range(0, 2) == 0)
               queue_item(KIND_BYTE, $urandom_range(0, 255));
         end else begin
            repeat ($urandom_range(1, 6))
               queue_item(2'($urandom_range(0, 3)), $urandom_range(0, 255));
         end
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------------------
   initial begin
      logic [7:0] prev;
      logic [7:0] b;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Fill the whole store first with one full-length frame so that every read
      // afterwards hits a written entry. No ticks and no terminator pair, so it
      // closes on buffer full at 64 bytes.
      prev = 8'h00;
      for (int k = 0; k < DEPTH; k++) begin
         b = 8'($urandom_range(0, 255));
         if (k > 0 && prev == cfg_end_first && b == cfg_end_second)
            b = b ^ 8'h01;
         queue_item(KIND_BYTE, b);
         prev = b;
      end

      // directed corners
      queue_item(KIND_READ, 0);
      queue_item(KIND_READ, 63);
      queue_item(KIND_BYTE, 8'hFF);        // dropped while pending, reloads timer
      queue_item(KIND_TICK, 0);
      queue_item(KIND_RELEASE, 0);
      queue_item(KIND_RELEASE, 0);         // nothing pending: no effect
      queue_item(KIND_BYTE, 8'h00);        // first byte opens a frame
      queue_item(KIND_BYTE, END_FIRST_RESET);
      queue_item(KIND_BYTE, END_SECOND_RESET);   // terminator pair closes at length 3
      queue_item(KIND_RELEASE, 0);
      queue_item(KIND_BYTE, 8'hFF);
      repeat (11) queue_item(KIND_TICK, 0);      // runs the timer out, last tick at zero
      queue_item(KIND_BYTE, 8'h55);        // timeout close, this byte is lost
      queue_item(KIND_RELEASE, 0);
      queue_item(KIND_READ, 63);
      random_traffic(150);

      // zero timeout and an all-zero terminator pair
      set_framing(8'h00, 8'h00, 8'h00);
      random_traffic(200);
      // bit 7 of the timeout write is dropped, so this is the longest timeout
      set_framing(8'hFF, 8'hFF, 8'hFF);
      random_traffic(150);
      set_framing(8'd1, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      random_traffic(200);
      set_framing(8'($urandom_range(2, 12)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
      random_traffic(200);
      set_framing(8'(IDLE_TIMEOUT_RESET), END_FIRST_RESET, END_SECOND_RESET);
      random_traffic(100);

      wait_idle();
      repeat (5) @(posedge clock);
      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

   // hard stop, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+design
design/urfa_pkg.sv
design/urfa_store.sv
design/urfa_framer.sv
design/uart_rx_frame_assembler.sv
sim/tb_uart_rx_frame_assembler.sv
